### rtl/core/key_click_long_press_detector_core_assert.svh
// Assertion macros for the key click / long press detector checker.
// Depends on nothing; included by the checker file only.
`ifndef KEY_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH
`define KEY_CLICK_LONG_PRESS_DETECTOR_CORE_ASSERT_SVH

// Clocked assertion, quiet while reset is high.
`define KCD_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define KCD_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/kcd_pkg.sv
// Shared types and constants for the key click / long press detector.
// Depends on nothing; used by every module of the block.
`default_nettype none

package kcd_pkg;

  localparam int SLOTS        = 8;
  localparam int NUM_KEYS_DEF = 8;
  localparam int PIN_W        = 8;
  localparam int BOUNCE_W     = 4;
  localparam int WINDOW_W     = 8;
  localparam int HOLD_W       = 10;
  localparam int CLICK_W      = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_IDX_W    = 3;

  localparam logic [BOUNCE_W-1:0] DEBOUNCE_RST = 4'd5;
  localparam logic [WINDOW_W-1:0] WINDOW_RST   = 8'd30;
  localparam logic [HOLD_W-1:0]   LONG_RST     = 10'd300;
  localparam logic [CLICK_W-1:0]  CLICK_MAX    = 2'd3;
  localparam logic [HOLD_W-1:0]   HOLD_MAX     = {HOLD_W{1'b1}};

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } key_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_WINDOW     = 3'd1,
    REG_LONG_PRESS = 3'd2,
    REG_DOUBLE_EN  = 3'd3,
    REG_LONG_EN    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BOUNCE_W-1:0] debounce_ticks;
    logic [WINDOW_W-1:0] double_window_ticks;
    logic [HOLD_W-1:0]   long_press_ticks;
    logic                double_click_enable;
    logic                long_press_enable;
  } kcd_cfg_t;

endpackage

`default_nettype wire

### rtl/core/kcd_pick.sv
// Priority pick of the first pressed pin and its mapping to a key slot.
// Depends on kcd_pkg.
`default_nettype none

module kcd_pick #(
  parameter int NUM_KEYS = kcd_pkg::NUM_KEYS_DEF
) (
  input  wire logic [kcd_pkg::PIN_W-1:0] pins,
  output logic      [kcd_pkg::SLOTS-1:0] pressed
);

  logic       found;
  logic [2:0] slot;

  // Pin p maps to slot (p + 4) mod 8; a slot at or above NUM_KEYS means no key.
  always_comb begin
    pressed = '0;
    found   = 1'b0;
    slot    = '0;
    for (int p = 0; p < kcd_pkg::PIN_W; p++) begin
      if (!found && !pins[p]) begin
        found = 1'b1;
        slot  = 3'(p + 4);
        if (int'(slot) < NUM_KEYS) begin
          pressed[slot] = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/kcd_slot.sv
// Per-key state: debounce, click counting, double-click window, hold timer.
// Depends on kcd_pkg.
`default_nettype none

module kcd_slot (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               level,
  input  wire kcd_pkg::kcd_cfg_t  cfg,
  output kcd_pkg::key_event_t     ev
);

  logic                         stable, stable_next;
  logic [kcd_pkg::BOUNCE_W-1:0] bounce, bounce_next;
  logic [kcd_pkg::CLICK_W-1:0]  clicks, clicks_next;
  logic [kcd_pkg::WINDOW_W-1:0] window, window_next;
  logic [kcd_pkg::HOLD_W-1:0]   hold, hold_next;
  logic                         long_mode, long_next;

  logic [kcd_pkg::BOUNCE_W:0]   bounce_inc;
  logic [kcd_pkg::WINDOW_W:0]   window_inc;
  logic [kcd_pkg::HOLD_W-1:0]   hold_inc;

  assign bounce_inc = {1'b0, bounce} + 1'b1;
  assign window_inc = (clicks != '0) ? {1'b0, window} + 1'b1 : '0;
  assign hold_inc   = hold + 1'b1;

  always_comb begin
    ev          = kcd_pkg::EV_NONE;
    stable_next = stable;
    bounce_next = bounce;
    clicks_next = clicks;
    window_next = window;
    hold_next   = hold;
    long_next   = long_mode;
    if (level != stable) begin
      if (bounce_inc > {1'b0, cfg.debounce_ticks}) begin
        bounce_next = '0;
        // accepted release that does not end a long press
        if (!level && !long_mode) begin
          if (cfg.double_click_enable) begin
            if (clicks != kcd_pkg::CLICK_MAX) begin
              clicks_next = clicks + 1'b1;
            end
          end else begin
            clicks_next = '0;
            ev          = kcd_pkg::EV_CLICK;
          end
        end
        stable_next = level;
      end else begin
        bounce_next = bounce_inc[kcd_pkg::BOUNCE_W-1:0];
      end
    end else begin
      bounce_next = '0;
      if (cfg.double_click_enable) begin
        if (window_inc > {1'b0, cfg.double_window_ticks}) begin
          window_next = '0;
          if (clicks == 2'd2) begin
            ev = kcd_pkg::EV_DOUBLE;
          end else if (clicks == 2'd1) begin
            ev = kcd_pkg::EV_CLICK;
          end
          clicks_next = '0;
        end else begin
          window_next = window_inc[kcd_pkg::WINDOW_W-1:0];
        end
      end
      // long press overrides a resolved click in the same tick
      if (cfg.long_press_enable) begin
        if (level) begin
          if (hold <= cfg.long_press_ticks && hold != kcd_pkg::HOLD_MAX) begin
            hold_next = hold_inc;
            if (hold_inc == cfg.long_press_ticks) begin
              long_next   = 1'b1;
              clicks_next = '0;
              ev          = kcd_pkg::EV_LONG;
            end
          end
        end else begin
          hold_next = '0;
          long_next = 1'b0;
        end
      end
    end
    if (!cfg.double_click_enable) begin
      clicks_next = '0;
    end
    if (!cfg.long_press_enable) begin
      hold_next = '0;
      long_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= 1'b0;
      bounce    <= '0;
      clicks    <= '0;
      window    <= '0;
      hold      <= '0;
      long_mode <= 1'b0;
    end else if (adv) begin
      stable    <= stable_next;
      bounce    <= bounce_next;
      clicks    <= clicks_next;
      window    <= window_next;
      hold      <= hold_next;
      long_mode <= long_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/key_click_long_press_detector_core.sv
// Top level of the key click / double click / long press detector.
// Depends on kcd_pkg, kcd_pick and kcd_slot.
//
// Usage:
//  - Input channel (in_valid / in_ready / key_pins): one beat per scan tick,
//    eight active-low pins. The first pressed pin in order 0..7 picks the
//    only key seen as pressed this tick; no pressed pin means all released.
//  - Output channel (out_valid / out_ready / event_key0..7): one beat per
//    input beat, a 2-bit event per key (none, click, double, long).
//  - Config port: cfg_wr_en writes cfg_wdata into register cfg_index at the
//    clock edge; unknown indexes are ignored. Write only while idle.
//  - Throughput: one beat per cycle while out_ready stays high. The input
//    register feeds the per-key update logic, which writes the result
//    register in the same cycle.
//  - Reset: key state clears, registers return to 5, 30, 300, 1, 1, and
//    both valid flags drop.
//  - Stall: while out_ready is low the result holds and the input register
//    keeps one more beat; in_ready then drops until the result is taken.
`default_nettype none

module key_click_long_press_detector_core #(
  parameter int NUM_KEYS = kcd_pkg::NUM_KEYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kcd_pkg::PIN_W-1:0]       key_pins,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           event_key0,
  output logic [1:0]                           event_key1,
  output logic [1:0]                           event_key2,
  output logic [1:0]                           event_key3,
  output logic [1:0]                           event_key4,
  output logic [1:0]                           event_key5,
  output logic [1:0]                           event_key6,
  output logic [1:0]                           event_key7,
  input  wire logic                            cfg_wr_en,
  input  wire logic [kcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  kcd_pkg::kcd_cfg_t   cfg;
  logic                s1_valid;
  logic [kcd_pkg::PIN_W-1:0] s1_pins;
  logic                adv;
  logic [kcd_pkg::SLOTS-1:0] pressed;
  kcd_pkg::key_event_t slot_ev [kcd_pkg::SLOTS];
  kcd_pkg::key_event_t ev_q    [kcd_pkg::SLOTS];

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= kcd_pkg::DEBOUNCE_RST;
      cfg.double_window_ticks <= kcd_pkg::WINDOW_RST;
      cfg.long_press_ticks    <= kcd_pkg::LONG_RST;
      cfg.double_click_enable <= 1'b1;
      cfg.long_press_enable   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (kcd_pkg::cfg_reg_t'(cfg_index))
        kcd_pkg::REG_DEBOUNCE:
          cfg.debounce_ticks <= cfg_wdata[kcd_pkg::BOUNCE_W-1:0];
        kcd_pkg::REG_WINDOW:
          cfg.double_window_ticks <= cfg_wdata[kcd_pkg::WINDOW_W-1:0];
        kcd_pkg::REG_LONG_PRESS:
          cfg.long_press_ticks <= cfg_wdata[kcd_pkg::HOLD_W-1:0];
        kcd_pkg::REG_DOUBLE_EN:
          cfg.double_click_enable <= cfg_wdata[0];
        kcd_pkg::REG_LONG_EN:
          cfg.long_press_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance the input beat into the result register whenever it is free.
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pins <= key_pins;
    end
  end

  kcd_pick #(.NUM_KEYS(NUM_KEYS)) u_pick (
    .pins    (s1_pins),
    .pressed (pressed)
  );

  // One slot per key; unused slots report no event.
  for (genvar i = 0; i < kcd_pkg::SLOTS; i++) begin : g_slot
    if (i < NUM_KEYS) begin : g_used
      kcd_slot u_slot (
        .clk   (clk),
        .rst   (rst),
        .adv   (adv),
        .level (pressed[i]),
        .cfg   (cfg),
        .ev    (slot_ev[i])
      );
    end else begin : g_unused
      assign slot_ev[i] = kcd_pkg::EV_NONE;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_q <= slot_ev;
    end
  end

  assign event_key0 = 2'(ev_q[0]);
  assign event_key1 = 2'(ev_q[1]);
  assign event_key2 = 2'(ev_q[2]);
  assign event_key3 = 2'(ev_q[3]);
  assign event_key4 = 2'(ev_q[4]);
  assign event_key5 = 2'(ev_q[5]);
  assign event_key6 = 2'(ev_q[6]);
  assign event_key7 = 2'(ev_q[7]);

endmodule

`default_nettype wire

### rtl/core/kcd_checker.sv
// Port-level checker for the key click / long press detector, with its bind.
// Depends on kcd_pkg and key_click_long_press_detector_core_assert.svh.
`default_nettype none

`include "key_click_long_press_detector_core_assert.svh"

module kcd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [1:0]                      event_key0,
  input wire logic [1:0]                      event_key1,
  input wire logic [1:0]                      event_key2,
  input wire logic [1:0]                      event_key3,
  input wire logic [1:0]                      event_key4,
  input wire logic [1:0]                      event_key5,
  input wire logic [1:0]                      event_key6,
  input wire logic [1:0]                      event_key7,
  input wire logic                            cfg_wr_en,
  input wire logic [kcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [kcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [15:0] evs;
  logic        dbl_en;
  logic        long_en;
  logic        any_double;
  logic        any_long;

  assign evs = {event_key7, event_key6, event_key5, event_key4,
                event_key3, event_key2, event_key1, event_key0};

  // Track the feature enables as written through the config port.
  always_ff @(posedge clk) begin
    if (rst) begin
      dbl_en  <= 1'b1;
      long_en <= 1'b1;
    end else if (cfg_wr_en) begin
      if (cfg_index == kcd_pkg::REG_DOUBLE_EN) begin
        dbl_en <= cfg_wdata[0];
      end
      if (cfg_index == kcd_pkg::REG_LONG_EN) begin
        long_en <= cfg_wdata[0];
      end
    end
  end

  always_comb begin
    any_double = 1'b0;
    any_long   = 1'b0;
    for (int k = 0; k < kcd_pkg::SLOTS; k++) begin
      if (evs[2*k +: 2] == kcd_pkg::EV_DOUBLE) any_double = 1'b1;
      if (evs[2*k +: 2] == kcd_pkg::EV_LONG)   any_long   = 1'b1;
    end
  end

  `KCD_ASSERT_RST(a_hold_on_stall, clk, rst, out_valid && !out_ready |=> out_valid && $stable(evs), "result changed while stalled")
  `KCD_ASSERT_ALL(a_reset_clears, clk, rst |=> !out_valid, "result valid right after reset")
  `KCD_ASSERT_RST(a_no_double_off, clk, rst, out_valid && !dbl_en |-> !any_double, "double click with feature off")
  `KCD_ASSERT_RST(a_no_long_off, clk, rst, out_valid && !long_en |-> !any_long, "long press with feature off")

endmodule

bind key_click_long_press_detector_core kcd_checker u_kcd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_key0 (event_key0),
  .event_key1 (event_key1),
  .event_key2 (event_key2),
  .event_key3 (event_key3),
  .event_key4 (event_key4),
  .event_key5 (event_key5),
  .event_key6 (event_key6),
  .event_key7 (event_key7),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);

`default_nettype wire
